@@ rtl/core/trs_pkg.sv @@
// ============================================================================
// trs_pkg
// Shared types and constants for the timestamped ring search block.
// ============================================================================
package trs_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int TIME_W   = 64;

    typedef enum logic [2:0] {
        ACT_PUSH_STAMPED   = 3'd0,
        ACT_PUSH_UNSTAMPED = 3'd1,
        ACT_FIND_EXACT     = 3'd2,
        ACT_FIND_NOT_AFTER = 3'd3,
        ACT_FIND_AFTER     = 3'd4,
        ACT_READ_TIME      = 3'd5,
        ACT_CHECK_SLOT     = 3'd6,
        ACT_BACK_FROM_HEAD = 3'd7
    } t_action;

    typedef struct packed {
        logic capture;
        logic push;
        logic rd_req;
        logic scan_init;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    ring_empty;
        logic    scan_done;
    } t_status;

endpackage

@@ rtl/core/trs_ram.sv @@
// ============================================================================
// trs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module trs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/trs_ctrl.sv @@
// ============================================================================
// trs_ctrl
// Sequencer: dispatches each word by action, steps the backward scan.
// ============================================================================
module trs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  trs_pkg::t_status i_status,
    output trs_pkg::t_cmd    o_cmd
);
    import trs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DISPATCH;
                    n_busy      = 1'b1;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.action)
                    ACT_PUSH_STAMPED, ACT_PUSH_UNSTAMPED: begin
                        cmd.push   = 1'b1;
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                        n_busy     = 1'b0;
                    end
                    ACT_FIND_EXACT, ACT_FIND_NOT_AFTER, ACT_FIND_AFTER: begin
                        if (i_status.ring_empty) begin
                            cmd.finish = 1'b1;
                            n_state    = S_IDLE;
                            n_busy     = 1'b0;
                        end else begin
                            cmd.scan_init = 1'b1;
                            n_state       = S_SCAN;
                        end
                    end
                    ACT_READ_TIME: begin
                        cmd.rd_req = 1'b1;
                        n_state    = S_READ;
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                        n_busy     = 1'b0;
                    end
                endcase
            end
            S_READ: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
                n_busy     = 1'b0;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                    n_busy     = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy  = r_busy;
    assign o_cmd = cmd;

endmodule

@@ rtl/core/trs_datapath.sv @@
// ============================================================================
// trs_datapath
// Ring state, timestamp RAM, scan pipeline and result registers.
// ============================================================================
module trs_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [2:0]                   i_action,
    input  logic [trs_pkg::TIME_W-1:0]   i_query_time,
    input  logic [trs_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [trs_pkg::SLOT_W-1:0]   i_back_position,
    input  logic                         i_verify,
    input  trs_pkg::t_cmd                i_cmd,
    output trs_pkg::t_status             o_status,
    output logic                         o_result_valid,
    output logic                         o_found,
    output logic [trs_pkg::SLOT_W-1:0]   o_slot,
    output logic [trs_pkg::TIME_W-1:0]   o_slot_time,
    output logic                         o_not_populated,
    output logic [trs_pkg::SLOT_W-1:0]   o_head_slot,
    output logic                         o_ring_empty,
    output logic                         o_ring_full
);
    import trs_pkg::*;

    // captured word
    t_action             r_action;
    logic [TIME_W-1:0]   r_qtime;
    logic [SLOT_W-1:0]   r_idx;
    logic [SLOT_W-1:0]   r_back;
    logic                r_verify;

    // ring state
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [CAPACITY-1:0] r_written;
    logic [CAPACITY-1:0] r_stamped;

    // scan pipeline
    logic [COUNT_W-1:0]  r_i;
    logic                r_cmp_valid;
    logic                r_cmp_last;
    logic                r_cmp_sv;
    logic [SLOT_W-1:0]   r_cmp_addr;

    // result
    logic                r_valid;
    logic                r_found;
    logic [SLOT_W-1:0]   r_slot;
    logic [TIME_W-1:0]   r_slot_time;
    logic                r_notpop;
    logic [SLOT_W-1:0]   r_head_slot;
    logic                r_empty;
    logic                r_full;

    logic [TIME_W-1:0]   ram_rdata;
    logic [SLOT_W-1:0]   ram_raddr;
    logic                ram_re;
    logic                ram_we;
    logic [SLOT_W-1:0]   scan_addr;
    logic                scan_issue;
    logic [TIME_W-1:0]   cmp_value;
    logic                match;
    logic                scan_hit;
    logic                is_push;
    logic                is_search;

    trs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CAPACITY)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (n_head),
        .i_wdata (r_qtime),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_push   = (r_action == ACT_PUSH_STAMPED) || (r_action == ACT_PUSH_UNSTAMPED);
    assign is_search = (r_action == ACT_FIND_EXACT) || (r_action == ACT_FIND_NOT_AFTER)
                    || (r_action == ACT_FIND_AFTER);

    assign n_head  = i_cmd.push ? r_head + SLOT_W'(1) : r_head;
    assign n_count = (i_cmd.push && (r_count != COUNT_W'(CAPACITY)))
                   ? r_count + COUNT_W'(1) : r_count;

    assign ram_we     = i_cmd.push && (r_action == ACT_PUSH_STAMPED);
    assign scan_addr  = r_head - r_i[SLOT_W-1:0];
    assign scan_issue = i_cmd.scan_step && (r_i < r_count);
    assign ram_re     = i_cmd.rd_req || scan_issue;
    assign ram_raddr  = i_cmd.rd_req ? r_idx : scan_addr;

    // never-stamped slots hold the reset time
    assign cmp_value = r_cmp_sv ? ram_rdata : '0;

    always_comb begin
        case (r_action)
            ACT_FIND_EXACT:     match = (cmp_value == r_qtime);
            ACT_FIND_NOT_AFTER: match = (cmp_value <= r_qtime);
            ACT_FIND_AFTER:     match = (cmp_value > r_qtime);
            default:            match = 1'b0;
        endcase
    end

    assign scan_hit = r_cmp_valid && match;

    assign o_status.action     = r_action;
    assign o_status.ring_empty = (r_count == '0);
    assign o_status.scan_done  = r_cmp_valid && (match || r_cmp_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_qtime  <= i_query_time;
            r_idx    <= i_slot_index;
            r_back   <= i_back_position;
            r_verify <= i_verify;
        end
        if (i_cmd.scan_init) begin
            r_i <= '0;
        end else if (scan_issue) begin
            r_i <= r_i + COUNT_W'(1);
        end
        if (scan_issue) begin
            r_cmp_last <= (r_i + COUNT_W'(1)) == r_count;
            r_cmp_sv   <= r_stamped[scan_addr];
            r_cmp_addr <= scan_addr;
        end
        if (i_cmd.finish) begin
            r_found     <= is_search && scan_hit;
            r_slot_time <= '0;
            r_notpop    <= 1'b0;
            r_head_slot <= n_head;
            r_empty     <= (n_count == '0);
            r_full      <= (n_count == COUNT_W'(CAPACITY));
            case (r_action)
                ACT_PUSH_STAMPED, ACT_PUSH_UNSTAMPED: begin
                    r_slot <= n_head;
                end
                ACT_FIND_EXACT, ACT_FIND_NOT_AFTER, ACT_FIND_AFTER: begin
                    r_slot <= scan_hit ? r_cmp_addr : '0;
                end
                ACT_READ_TIME: begin
                    r_slot <= r_idx;
                    if (r_written[r_idx]) begin
                        r_slot_time <= r_stamped[r_idx] ? ram_rdata : '0;
                    end else begin
                        r_notpop <= 1'b1;
                    end
                end
                ACT_CHECK_SLOT: begin
                    r_slot   <= r_idx;
                    r_notpop <= r_verify && !r_written[r_idx];
                end
                default: begin
                    r_slot <= r_head - r_back;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_written   <= '0;
            r_stamped   <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_cmp_valid <= scan_issue;
            r_valid     <= i_cmd.finish;
            if (i_cmd.push && is_push) begin
                r_written[n_head] <= 1'b1;
                if (r_action == ACT_PUSH_STAMPED) begin
                    r_stamped[n_head] <= 1'b1;
                end
            end
        end
    end

    assign o_result_valid  = r_valid;
    assign o_found         = r_found;
    assign o_slot          = r_slot;
    assign o_slot_time     = r_slot_time;
    assign o_not_populated = r_notpop;
    assign o_head_slot     = r_head_slot;
    assign o_ring_empty    = r_empty;
    assign o_ring_full     = r_full;

endmodule

@@ rtl/core/timestamped_ring_search_top.sv @@
// ============================================================================
// timestamped_ring_search_top
// Push, check slot and back from head finish at dispatch; read time waits on
// one timestamp RAM read; searches finish at once on an empty ring, else scan
// back from the head, one timestamp RAM read per cycle, until a match or the
// oldest slot. One word at a time; busy high until the result strobe. Results
// are never stalled. Synchronous reset clears head, count and slot flags; no
// clearing pass is needed.
// ============================================================================
module timestamped_ring_search_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_action,
    input  logic [trs_pkg::TIME_W-1:0] i_query_time,
    input  logic [trs_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [trs_pkg::SLOT_W-1:0] i_back_position,
    input  logic                       i_verify,
    output logic                       o_result_valid,
    output logic                       o_found,
    output logic [trs_pkg::SLOT_W-1:0] o_slot,
    output logic [trs_pkg::TIME_W-1:0] o_slot_time,
    output logic                       o_not_populated,
    output logic [trs_pkg::SLOT_W-1:0] o_head_slot,
    output logic                       o_ring_empty,
    output logic                       o_ring_full
);
    import trs_pkg::*;

    t_cmd    cmd;
    t_status status;

    trs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    trs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_action),
        .i_query_time    (i_query_time),
        .i_slot_index    (i_slot_index),
        .i_back_position (i_back_position),
        .i_verify        (i_verify),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_valid  (o_result_valid),
        .o_found         (o_found),
        .o_slot          (o_slot),
        .o_slot_time     (o_slot_time),
        .o_not_populated (o_not_populated),
        .o_head_slot     (o_head_slot),
        .o_ring_empty    (o_ring_empty),
        .o_ring_full     (o_ring_full)
    );

endmodule

@@ verif/timestamped_ring_search_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// timestamped_ring_search_top_tb
// Self-checking bench for the timestamped ring search block. Directed words
// cover the empty ring, timestamp extremes and every action. Random words
// follow: first on a partly filled ring, then back to back with no gaps, and
// last on a wrapped ring. A local ring predictor builds the expected result
// of each accepted word, and each result strobe is compared against it.
// ============================================================================
module timestamped_ring_search_top_tb;
    import trs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] slot_time;
        logic              not_populated;
        logic [SLOT_W-1:0] head_slot;
        logic              ring_empty;
        logic              ring_full;
    } t_result;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              start           = 1'b0;
    logic [2:0]        i_action        = '0;
    logic [TIME_W-1:0] i_query_time    = '0;
    logic [SLOT_W-1:0] i_slot_index    = '0;
    logic [SLOT_W-1:0] i_back_position = '0;
    logic              i_verify        = 1'b0;
    logic              busy;
    logic              o_result_valid;
    logic              o_found;
    logic [SLOT_W-1:0] o_slot;
    logic [TIME_W-1:0] o_slot_time;
    logic              o_not_populated;
    logic [SLOT_W-1:0] o_head_slot;
    logic              o_ring_empty;
    logic              o_ring_full;

    // ring predictor state
    logic [TIME_W-1:0] stamp_mem [CAPACITY];
    bit                written_mem [CAPACITY];
    logic [SLOT_W-1:0] head_ptr    = '0;
    int                push_total  = 0;
    logic [TIME_W-1:0] time_base   = 64'd100;

    t_result           pending_results [$];
    t_result           observed;
    t_result           predicted;
    int                mismatch_cnt = 0;
    int                stall_cycles = 0;
    bit                gaps_enabled = 1'b1;

    timestamped_ring_search_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_query_time    (i_query_time),
        .i_slot_index    (i_slot_index),
        .i_back_position (i_back_position),
        .i_verify        (i_verify),
        .o_result_valid  (o_result_valid),
        .o_found         (o_found),
        .o_slot          (o_slot),
        .o_slot_time     (o_slot_time),
        .o_not_populated (o_not_populated),
        .o_head_slot     (o_head_slot),
        .o_ring_empty    (o_ring_empty),
        .o_ring_full     (o_ring_full)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            stamp_mem[i]   = '0;
            written_mem[i] = 1'b0;
        end
    end

    task automatic ring_predict(input t_action act, input logic [TIME_W-1:0] qt,
                                input logic [SLOT_W-1:0] idx,
                                input logic [SLOT_W-1:0] back, input logic vfy);
        t_result           r;
        int                n;
        int                pos;
        logic [TIME_W-1:0] v;
        logic              hit;
        r = '0;
        case (act)
            ACT_PUSH_STAMPED, ACT_PUSH_UNSTAMPED: begin
                head_ptr = SLOT_W'((int'(head_ptr) + 1) % CAPACITY);
                if (act == ACT_PUSH_STAMPED)
                    stamp_mem[head_ptr] = qt;
                written_mem[head_ptr] = 1'b1;
                if (push_total < CAPACITY)
                    push_total++;
                r.slot = head_ptr;
            end
            ACT_FIND_EXACT, ACT_FIND_NOT_AFTER, ACT_FIND_AFTER: begin
                n = (push_total < CAPACITY) ? push_total : CAPACITY;
                for (int i = 0; i < n && !r.found; i++) begin
                    pos = (int'(head_ptr) + CAPACITY - i) % CAPACITY;
                    v   = stamp_mem[SLOT_W'(pos)];
                    if (act == ACT_FIND_EXACT)
                        hit = (v == qt);
                    else if (act == ACT_FIND_NOT_AFTER)
                        hit = (v <= qt);
                    else
                        hit = (v > qt);
                    if (hit) begin
                        r.found = 1'b1;
                        r.slot  = SLOT_W'(pos);
                    end
                end
            end
            ACT_READ_TIME: begin
                r.slot = idx;
                if (int'(idx) < CAPACITY && written_mem[idx])
                    r.slot_time = stamp_mem[idx];
                else
                    r.not_populated = 1'b1;
            end
            ACT_CHECK_SLOT: begin
                r.slot = idx;
                if (vfy && !(int'(idx) < CAPACITY && written_mem[idx]))
                    r.not_populated = 1'b1;
            end
            default: begin
                r.slot = SLOT_W'((int'(head_ptr) + CAPACITY - int'(back) % CAPACITY)
                                 % CAPACITY);
            end
        endcase
        r.head_slot  = head_ptr;
        r.ring_empty = (push_total == 0);
        r.ring_full  = (push_total >= CAPACITY);
        pending_results.push_back(r);
    endtask

    task automatic send_word(input t_action act, input logic [TIME_W-1:0] qt,
                             input logic [SLOT_W-1:0] idx,
                             input logic [SLOT_W-1:0] back, input logic vfy);
        start           <= 1'b1;
        i_action        <= act;
        i_query_time    <= qt;
        i_slot_index    <= idx;
        i_back_position <= back;
        i_verify        <= vfy;
        do @(posedge i_clk); while (busy !== 1'b0);
        ring_predict(act, qt, idx, back, vfy);
    endtask

    task automatic idle_gap();
        if (gaps_enabled && $urandom_range(99) < 22) begin
            start           <= 1'b0;
            i_action        <= 3'($urandom);
            i_query_time    <= {$urandom, $urandom};
            i_slot_index    <= SLOT_W'($urandom);
            i_back_position <= SLOT_W'($urandom);
            i_verify        <= 1'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // in four of ten picks, pushes follow a rising clock and searches aim at or next to a stored stamp
    function automatic logic [TIME_W-1:0] pick_time(input bit for_push);
        logic [TIME_W-1:0] t;
        int                sel;
        sel = $urandom_range(9);
        if (sel < 4) begin
            if (for_push) begin
                time_base = time_base + TIME_W'($urandom_range(3));
                t = time_base;
            end else begin
                t = stamp_mem[SLOT_W'($urandom_range(CAPACITY - 1))]
                    + TIME_W'($urandom_range(2)) - TIME_W'(1);
            end
        end else if (sel < 7) begin
            t = TIME_W'($urandom_range(31));
        end else if (sel < 9) begin
            t = {$urandom, $urandom};
        end else begin
            t = $urandom_range(1) ? '1 : '0;
        end
        return t;
    endfunction

    task automatic send_random(input int push_pct);
        t_action act;
        bit      is_push;
        is_push = ($urandom_range(99) < push_pct);
        if (is_push)
            act = ($urandom_range(4) == 0) ? ACT_PUSH_UNSTAMPED : ACT_PUSH_STAMPED;
        else
            act = t_action'($urandom_range(int'(ACT_BACK_FROM_HEAD),
                                           int'(ACT_FIND_EXACT)));
        send_word(act, pick_time(is_push), SLOT_W'($urandom), SLOT_W'($urandom),
                  1'($urandom));
        idle_gap();
    endtask

    task automatic test_empty_ring();
        send_word(ACT_FIND_EXACT,     '0, '0, '0, 1'b0);
        send_word(ACT_FIND_NOT_AFTER, '1, '0, '0, 1'b0);
        send_word(ACT_FIND_AFTER,     '0, '0, '0, 1'b0);
        send_word(ACT_READ_TIME,      '0, '0, '0, 1'b0);
        send_word(ACT_CHECK_SLOT,     '0, '1, '0, 1'b1);
        send_word(ACT_CHECK_SLOT,     '0, 6'd5, '0, 1'b0);
        send_word(ACT_BACK_FROM_HEAD, '0, '0, '0, 1'b0);
        send_word(ACT_BACK_FROM_HEAD, '0, '0, '1, 1'b0);
    endtask

    task automatic test_push_and_lookup();
        send_word(ACT_PUSH_STAMPED,   '1, '0, '0, 1'b0);
        send_word(ACT_PUSH_STAMPED,   '0, '1, '1, 1'b1);
        send_word(ACT_PUSH_UNSTAMPED, 64'hdead_beef_0000_0001, '0, '0, 1'b0);
        send_word(ACT_PUSH_STAMPED,   64'h5555_5555_aaaa_aaaa, '0, '0, 1'b0);
        send_word(ACT_FIND_EXACT,     '1, '0, '0, 1'b0);
        send_word(ACT_FIND_EXACT,     '0, '0, '0, 1'b0);
        send_word(ACT_FIND_NOT_AFTER, 64'd1, '0, '0, 1'b0);
        send_word(ACT_FIND_AFTER,     '1, '0, '0, 1'b0);
        send_word(ACT_FIND_AFTER,     '0, '0, '0, 1'b0);
        send_word(ACT_READ_TIME,      '0, 6'd1, '0, 1'b0);
        send_word(ACT_READ_TIME,      '0, 6'd0, '0, 1'b0);
        send_word(ACT_CHECK_SLOT,     '0, 6'd4, '0, 1'b1);
        send_word(ACT_CHECK_SLOT,     '0, 6'd0, '0, 1'b1);
        send_word(ACT_BACK_FROM_HEAD, '0, '0, 6'd1, 1'b0);
        send_word(ACT_BACK_FROM_HEAD, '0, '0, '1, 1'b0);
    endtask

    task automatic test_partial_ring();
        repeat (300) send_random(8);
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        repeat (300) send_random(30);
        gaps_enabled = 1'b1;
    endtask

    task automatic test_wrapped_ring();
        repeat (1200) send_random(30);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_ring();
        test_push_and_lookup();
        test_partial_ring();
        test_back_to_back();
        test_wrapped_ring();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            observed = '{o_found, o_slot, o_slot_time, o_not_populated,
                         o_head_slot, o_ring_empty, o_ring_full};
            if (pending_results.size() == 0) begin
                if (mismatch_cnt < REPORT_LIMIT)
                    $display("unexpected result word: slot=%0d head=%0d", o_slot,
                             o_head_slot);
                mismatch_cnt++;
            end else begin
                predicted = pending_results.pop_front();
                if (observed !== predicted) begin
                    if (mismatch_cnt < REPORT_LIMIT)
                        $display({"result mismatch: exp found=%0d slot=%0d time=%h ",
                                  "np=%0d head=%0d empty=%0d full=%0d | got found=%0d ",
                                  "slot=%0d time=%h np=%0d head=%0d empty=%0d full=%0d"},
                                 predicted.found, predicted.slot, predicted.slot_time,
                                 predicted.not_populated, predicted.head_slot,
                                 predicted.ring_empty, predicted.ring_full,
                                 observed.found, observed.slot, observed.slot_time,
                                 observed.not_populated, observed.head_slot,
                                 observed.ring_empty, observed.ring_full);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if ((start && busy === 1'b0) || o_result_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
